/* rtl/heightmap_normal_map_unit_assert.svh */
// ----------------------------------------------------------------------------
// heightmap normal map assertion macros
// concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_NORMAL_MAP_UNIT_ASSERT_SVH
`define HEIGHTMAP_NORMAL_MAP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define HMN_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen out of reset
`define HMN_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HMN_ASSERT(label, clk, rst_n, prop, msg)
`define HMN_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/hmn_pkg.sv */
// ----------------------------------------------------------------------------
// hmn_pkg
// shared types and constants of the heightmap normal map unit
// ----------------------------------------------------------------------------
`default_nettype none

package hmn_pkg;

  localparam int PIX_W      = 8;
  localparam int HEIGHT_W   = 8;
  localparam int HSUM_W     = 13;
  localparam int GRAD_W     = 8;
  localparam int OUT_COL_W  = 11;
  localparam int OUT_ROW_W  = 12;
  localparam int LB_W       = 2 * HEIGHT_W;

  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;

  localparam int CFG_WIDTH_RESET  = 2048;
  localparam int CFG_HEIGHT_RESET = 4096;
  localparam int CFG_GAIN_RESET   = 10;
  localparam int CFG_BIAS_RESET   = 128;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam int NUM_SLOTS = 3;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_GAIN   = 2'd2,
    REG_BIAS   = 2'd3
  } cfg_reg_t;

  // result slots of one job, in emission order
  typedef enum logic [1:0] {
    SLOT_ABOVE  = 2'd0,
    SLOT_BEHIND = 2'd1,
    SLOT_CORNER = 2'd2
  } slot_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix_red;
    logic [PIX_W-1:0] pix_green;
    logic [PIX_W-1:0] pix_blue;
  } pix_t;

  typedef struct packed {
    logic [GRAD_W-1:0]    normal_x;
    logic [GRAD_W-1:0]    normal_y;
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    logic                 last_of_run;
    logic                 frame_done;
  } nrm_t;

  typedef struct packed {
    cfg_reg_t              reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
  } cfg_t;

  // one classified pixel: wrapped differences for each result it causes
  typedef struct packed {
    logic [NUM_SLOTS-1:0]               mask;
    logic [NUM_SLOTS-1:0][GRAD_W-1:0]   dx;
    logic [NUM_SLOTS-1:0][GRAD_W-1:0]   dy;
    logic [OUT_COL_W-1:0]               col;
    logic [OUT_ROW_W-1:0]               row;
  } job_t;

endpackage

`default_nettype wire

/* rtl/hmn_if.sv */
// ----------------------------------------------------------------------------
// hmn_if
// valid/ready channels of the heightmap normal map unit
// ----------------------------------------------------------------------------
`default_nettype none

interface hmn_pix_if;
  import hmn_pkg::*;
  logic valid;
  logic ready;
  pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hmn_nrm_if;
  import hmn_pkg::*;
  logic valid;
  logic ready;
  nrm_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hmn_cfg_if;
  import hmn_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/heightmap_normal_map_unit.sv */
// ----------------------------------------------------------------------------
// heightmap_normal_map_unit
// streaming height map to normal map converter, central differences
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                                            beat when
//  in_pix    in    pix_red, pix_green, pix_blue                       valid & ready
//  out_nrm   out   normal_x, normal_y, out_col, out_row,
//                  last_of_run, frame_done                            valid & ready
//  cfg_wr    in    reg_index, wr_data                                 valid & ready
//
//  one pixel per clock while the output is not stalled; a result passes the
//  s1 registers, the job queue and the output register, which moves one
//  result per cycle while the receiver is ready, so in the bottom row (up to
//  two results per pixel, up to three on the last one) intake slows down
//  reset is synchronous; no clearing pass, every line buffer entry is
//  written in a row before the next row reads it
//  front and back stall independently through a four-entry job queue
//
`default_nettype none

`include "heightmap_normal_map_unit_assert.svh"

module heightmap_normal_map_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  hmn_pix_if.sink    in_pix,
  hmn_nrm_if.source  out_nrm,
  hmn_cfg_if.sink    cfg_wr
);
  import hmn_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH) + 1;
  localparam int HW = $clog2(MAX_HEIGHT) + 1;

  // reset sizes, already held to the build limits
  localparam int W_RST = (CFG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RESET;
  localparam int H_RST = (CFG_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_HEIGHT_RESET;

  // ---- configuration registers ----
  // sizes are stored already clamped: zero acts as one, oversize as the limit
  logic [WW-1:0]           w_eff_r, w_eff_nxt, w_clamp;
  logic [HW-1:0]           h_eff_r, h_eff_nxt, h_clamp;
  logic [GRAD_W-1:0]       gain_r, gain_nxt;
  logic [GRAD_W-1:0]       bias_r, bias_nxt;
  logic [CFG_WIDTH_W-1:0]  cfg_w;
  logic [CFG_HEIGHT_W-1:0] cfg_h;
  logic                    cfg_acc;

  // ---- front to queue to back ----
  job_t f_job, q_head;
  logic f_job_valid, f_job_ready;
  logic q_pop_valid, q_pop_ready;

  // always open; user writes must land only while idle, the block does not check
  assign cfg_wr.ready = 1'b1;
  assign cfg_acc      = cfg_wr.valid && cfg_wr.ready;
  assign cfg_w        = cfg_wr.data.wr_data[CFG_WIDTH_W-1:0];
  assign cfg_h        = cfg_wr.data.wr_data[CFG_HEIGHT_W-1:0];

  always_comb begin
    if (cfg_w == '0) begin
      w_clamp = WW'(1);
    end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(cfg_w);
    end
    if (cfg_h == '0) begin
      h_clamp = HW'(1);
    end else if (32'(cfg_h) > 32'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(cfg_h);
    end
  end

  always_comb begin
    w_eff_nxt = w_eff_r;
    h_eff_nxt = h_eff_r;
    gain_nxt  = gain_r;
    bias_nxt  = bias_r;
    if (cfg_acc) begin
      case (cfg_wr.data.reg_index)
        REG_WIDTH:  w_eff_nxt = w_clamp;
        REG_HEIGHT: h_eff_nxt = h_clamp;
        REG_GAIN:   gain_nxt  = cfg_wr.data.wr_data[GRAD_W-1:0];
        REG_BIAS:   bias_nxt  = cfg_wr.data.wr_data[GRAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= WW'(W_RST);
      h_eff_r <= HW'(H_RST);
      gain_r  <= GRAD_W'(CFG_GAIN_RESET);
      bias_r  <= GRAD_W'(CFG_BIAS_RESET);
    end else begin
      w_eff_r <= w_eff_nxt;
      h_eff_r <= h_eff_nxt;
      gain_r  <= gain_nxt;
      bias_r  <= bias_nxt;
    end
  end

  // front: raster position, height, line buffer, job classification
  hmn_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .w_eff     (w_eff_r),
    .h_eff     (h_eff_r),
    .job_valid (f_job_valid),
    .job_ready (f_job_ready),
    .job       (f_job)
  );

  // jobs with no result never enter the queue
  hmn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_job_valid),
    .push_ready (f_job_ready),
    .push_data  (f_job),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_head)
  );

  // back: one result per cycle into the output register while it is free
  hmn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_pop_valid),
    .job_ready (q_pop_ready),
    .job       (q_head),
    .gain      (gain_r),
    .bias      (bias_r),
    .out_nrm   (out_nrm)
  );

  // ---- checks ----
  `HMN_ASSERT_NEVER(a_no_empty_job, clk, rst_n, q_pop_valid && (q_head.mask == '0), "queued job without results")
  `HMN_ASSERT(a_pop_loads_out, clk, rst_n, q_pop_valid && q_pop_ready |=> out_nrm.valid, "job retired without a result")
  `HMN_ASSERT(a_frame_end_last, clk, rst_n, out_nrm.valid && out_nrm.data.frame_done |-> out_nrm.data.last_of_run, "frame end result not last of its run")

endmodule

`default_nettype wire

/* rtl/hmn_queue.sv */
// ----------------------------------------------------------------------------
// hmn_queue
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module hmn_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  hmn_pkg::job_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output hmn_pkg::job_t  pop_data
);
  import hmn_pkg::*;

  job_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = q_mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/hmn_front.sv */
// ----------------------------------------------------------------------------
// hmn_front
// pixel intake: raster position, gray height, line buffer and job forming
// ----------------------------------------------------------------------------
`default_nettype none

module hmn_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  hmn_pix_if.sink                      in_pix,
  input  logic [$clog2(MAX_WIDTH):0]   w_eff,
  input  logic [$clog2(MAX_HEIGHT):0]  h_eff,
  output logic                         job_valid,
  input  logic                         job_ready,
  output hmn_pkg::job_t                job
);
  import hmn_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = XW + 1;
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int HW = YW + 1;

  // raster position counters
  logic [XW-1:0] cnt_x_r, cnt_x_nxt;
  logic [YW-1:0] cnt_y_r, cnt_y_nxt;

  // intake side
  logic                acc;
  logic                restart, wrap;
  logic [HW-1:0]       y_inc;
  logic [YW-1:0]       y_wrapped;
  logic [XW-1:0]       x;
  logic [YW-1:0]       y;
  logic [WW-1:0]       x1;
  logic [HW-1:0]       y1;
  logic                last_col, last_row;
  logic [HSUM_W-1:0]   h_sum;
  logic [XW-1:0]       addr_a, addr_b;

  // line buffer: {row above, row two above} per column
  logic [LB_W-1:0]     lbuf_mem [MAX_WIDTH];
  logic [LB_W-1:0]     rd_a_r;
  logic [HEIGHT_W-1:0] rd_b_r;
  logic                byp_a_r, byp_b_r;
  logic [LB_W-1:0]     byp_word_r;
  logic                wr_en;
  logic [XW-1:0]       wr_addr;
  logic [LB_W-1:0]     wr_word;

  // stage one
  logic                 s1_valid_r, s1_valid_nxt;
  logic [XW-1:0]        s1_x_r;
  logic [HEIGHT_W-1:0]  s1_h_r;
  logic [OUT_COL_W-1:0] s1_col_r;
  logic [OUT_ROW_W-1:0] s1_row_r;
  logic                 s1_up_r, s1_up2_r, s1_xgt0_r, s1_xge2_r;
  logic                 s1_right_r, s1_lcol_r, s1_lrow_r;
  logic [NUM_SLOTS-1:0] s1_mask;
  logic                 s1_pass, adv;

  // job forming
  logic [LB_W-1:0]      word_a;
  logic [HEIGHT_W-1:0]  c, two, rnb;
  logic [HEIGHT_W-1:0]  l1, r1, u1, l2, u2, l3, u3;
  logic [HEIGHT_W-1:0]  prev_c_r;
  logic [HEIGHT_W-1:0]  rh0_r, rh1_r;

  // ---- intake and position ----
  assign s1_mask[SLOT_ABOVE]  = s1_up_r;
  assign s1_mask[SLOT_BEHIND] = s1_lrow_r && s1_xgt0_r;
  assign s1_mask[SLOT_CORNER] = s1_lrow_r && s1_lcol_r;
  assign s1_pass      = (s1_mask == '0) || job_ready;
  assign adv          = s1_valid_r && s1_pass;
  assign in_pix.ready = !s1_valid_r || s1_pass;
  assign acc          = in_pix.valid && in_pix.ready;

  always_comb begin
    restart   = (HW'(cnt_y_r) >= h_eff);
    wrap      = !restart && (WW'(cnt_x_r) >= w_eff);
    y_inc     = HW'(cnt_y_r) + HW'(1);
    y_wrapped = (y_inc >= h_eff) ? '0 : y_inc[YW-1:0];
    x         = (restart || wrap) ? '0 : cnt_x_r;
    if (restart) begin
      y = '0;
    end else if (wrap) begin
      y = y_wrapped;
    end else begin
      y = cnt_y_r;
    end
    x1       = WW'(x) + WW'(1);
    y1       = HW'(y) + HW'(1);
    last_col = (x1 == w_eff);
    last_row = (y1 == h_eff);
    addr_a   = x;
    addr_b   = x1[XW-1:0];
  end

  always_comb begin
    cnt_x_nxt = cnt_x_r;
    cnt_y_nxt = cnt_y_r;
    if (acc) begin
      if (last_col) begin
        cnt_x_nxt = '0;
        cnt_y_nxt = last_row ? '0 : y1[YW-1:0];
      end else begin
        cnt_x_nxt = x1[XW-1:0];
        cnt_y_nxt = y;
      end
    end
  end

  // gray weighting r*11 + g*16 + b*5, then divide by 32
  always_comb begin
    h_sum = HSUM_W'({in_pix.data.pix_red, 3'b000}) + HSUM_W'({in_pix.data.pix_red, 1'b0})
          + HSUM_W'(in_pix.data.pix_red) + HSUM_W'({in_pix.data.pix_green, 4'b0000})
          + HSUM_W'({in_pix.data.pix_blue, 2'b00}) + HSUM_W'(in_pix.data.pix_blue);
  end

  assign s1_valid_nxt = acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_x_r    <= '0;
      cnt_y_r    <= '0;
      s1_valid_r <= 1'b0;
      rh0_r      <= '0;
      rh1_r      <= '0;
    end else begin
      cnt_x_r    <= cnt_x_nxt;
      cnt_y_r    <= cnt_y_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (adv) begin
        rh1_r <= rh0_r;
        rh0_r <= s1_h_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_x_r     <= x;
      s1_h_r     <= h_sum[HSUM_W-1:HSUM_W-HEIGHT_W];
      s1_col_r   <= OUT_COL_W'(x);
      s1_row_r   <= OUT_ROW_W'(y);
      s1_up_r    <= (y != '0);
      s1_up2_r   <= (HW'(y) >= HW'(2));
      s1_xgt0_r  <= (x != '0);
      s1_xge2_r  <= (WW'(x) >= WW'(2));
      s1_right_r <= (x1 < w_eff);
      s1_lcol_r  <= last_col;
      s1_lrow_r  <= last_row;
      // same-cycle write of the previous pixel wins over the array read
      byp_a_r    <= wr_en && (wr_addr == addr_a);
      byp_b_r    <= wr_en && (wr_addr == addr_b);
      byp_word_r <= wr_word;
    end
    if (adv) begin
      prev_c_r <= c;
    end
  end

  // ---- line buffer ----
  assign wr_en   = adv;
  assign wr_addr = s1_x_r;
  assign wr_word = {s1_h_r, c};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lbuf_mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_a_r <= lbuf_mem[addr_a];
      rd_b_r <= lbuf_mem[addr_b][LB_W-1:HEIGHT_W];
    end
  end

  // ---- job forming ----
  always_comb begin
    word_a = byp_a_r ? byp_word_r : rd_a_r;
    c      = word_a[LB_W-1:HEIGHT_W];
    two    = word_a[HEIGHT_W-1:0];
    rnb    = byp_b_r ? byp_word_r[LB_W-1:HEIGHT_W] : rd_b_r;

    // pixel one row up, at this column
    l1 = s1_xgt0_r ? prev_c_r : c;
    r1 = s1_right_r ? rnb : c;
    u1 = s1_up2_r ? two : c;
    // bottom row, one column behind
    l2 = s1_xge2_r ? rh1_r : rh0_r;
    u2 = s1_up_r ? prev_c_r : rh0_r;
    // bottom right corner
    l3 = s1_xgt0_r ? rh0_r : s1_h_r;
    u3 = s1_up_r ? c : s1_h_r;

    job.mask             = s1_mask;
    job.dx[SLOT_ABOVE]   = l1 - r1;
    job.dy[SLOT_ABOVE]   = u1 - s1_h_r;
    job.dx[SLOT_BEHIND]  = l2 - s1_h_r;
    job.dy[SLOT_BEHIND]  = u2 - rh0_r;
    job.dx[SLOT_CORNER]  = l3 - s1_h_r;
    job.dy[SLOT_CORNER]  = u3 - s1_h_r;
    job.col              = s1_col_r;
    job.row              = s1_row_r;
  end

  assign job_valid = s1_valid_r && (s1_mask != '0);

endmodule

`default_nettype wire

/* rtl/hmn_back.sv */
// ----------------------------------------------------------------------------
// hmn_back
// walks the results of each job and scales the differences into bytes
// ----------------------------------------------------------------------------
`default_nettype none

module hmn_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  hmn_pkg::job_t               job,
  input  logic [hmn_pkg::GRAD_W-1:0]  gain,
  input  logic [hmn_pkg::GRAD_W-1:0]  bias,
  hmn_nrm_if.source                   out_nrm
);
  import hmn_pkg::*;

  logic [NUM_SLOTS-1:0]  done_r, done_nxt;
  logic [NUM_SLOTS-1:0]  pend, sel, rest;
  slot_t                 slot;
  logic                  last, out_free, load;
  logic [GRAD_W-1:0]     dx_sel, dy_sel;
  logic [2*GRAD_W-1:0]   prod_x, prod_y;
  logic                  out_valid_r, out_valid_nxt;
  nrm_t                  out_data_r, out_data_nxt;

  assign pend = job.mask & ~done_r;

  always_comb begin
    if (pend[SLOT_ABOVE]) begin
      slot = SLOT_ABOVE;
    end else if (pend[SLOT_BEHIND]) begin
      slot = SLOT_BEHIND;
    end else begin
      slot = SLOT_CORNER;
    end
  end

  always_comb begin
    sel = '0;
    case (slot)
      SLOT_ABOVE: begin
        sel[SLOT_ABOVE] = 1'b1;
        dx_sel = job.dx[SLOT_ABOVE];
        dy_sel = job.dy[SLOT_ABOVE];
      end
      SLOT_BEHIND: begin
        sel[SLOT_BEHIND] = 1'b1;
        dx_sel = job.dx[SLOT_BEHIND];
        dy_sel = job.dy[SLOT_BEHIND];
      end
      SLOT_CORNER: begin
        sel[SLOT_CORNER] = 1'b1;
        dx_sel = job.dx[SLOT_CORNER];
        dy_sel = job.dy[SLOT_CORNER];
      end
      default: begin
        dx_sel = '0;
        dy_sel = '0;
      end
    endcase
  end

  assign rest      = pend & ~sel;
  assign last      = (rest == '0);
  assign out_free  = !out_valid_r || out_nrm.ready;
  assign load      = job_valid && (pend != '0) && out_free;
  assign job_ready = load && last;

  always_comb begin
    done_nxt = done_r;
    if (job_ready) begin
      done_nxt = '0;
    end else if (load) begin
      done_nxt = done_r | sel;
    end
  end

  // only the low byte of the product survives the wrap
  always_comb begin
    prod_x = dx_sel * gain;
    prod_y = dy_sel * gain;
    out_data_nxt.normal_x    = bias + prod_x[GRAD_W-1:0];
    out_data_nxt.normal_y    = bias + prod_y[GRAD_W-1:0];
    out_data_nxt.out_col     = (slot == SLOT_BEHIND) ? job.col - OUT_COL_W'(1) : job.col;
    out_data_nxt.out_row     = (slot == SLOT_ABOVE) ? job.row - OUT_ROW_W'(1) : job.row;
    out_data_nxt.last_of_run = last;
    out_data_nxt.frame_done  = (slot == SLOT_CORNER);
  end

  assign out_valid_nxt = load ? 1'b1 : (out_nrm.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_nrm.valid = out_valid_r;
  assign out_nrm.data  = out_data_r;

endmodule

`default_nettype wire

/* dv/tb_heightmap_normal_map_unit.sv */
// ----------------------------------------------------------------------------
// tb_heightmap_normal_map_unit
// self-checking bench for the height map to normal map converter: pixels
// stream in raster order, an in-bench model of the line buffers predicts
// every normal beat and a scoreboard compares each field in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_heightmap_normal_map_unit;
  import hmn_pkg::*;

  localparam int          MAX_COLS      = 2048;
  localparam int          MAX_ROWS      = 4096;
  // pipeline stages plus a four-entry job queue
  localparam int          SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int          RANDOM_ITEMS  = 140;
  // random frames past this many items run with no idling at all
  localparam int          CALM_TAIL_AT  = 100;
  // pixels sent into the oversized row and column frames
  localparam int          EDGE_ITEMS    = 24;
  localparam int          PRINT_CAP     = 100;

  // --------------------------------------------------------------------------
  // line buffer model and in-order scoreboard of normal beats
  // --------------------------------------------------------------------------
  class normal_map_checker;
    logic [7:0]  row_above [MAX_COLS];
    logic [7:0]  row_two_above [MAX_COLS];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [7:0]  last_height;
    logic [7:0]  prev_height;
    int unsigned width_reg;
    int unsigned height_reg;
    logic [7:0]  gain;
    logic [7:0]  bias;
    nrm_t        pending_normals[$];
    int          mismatches;

    function new();
      foreach (row_above[i]) begin
        row_above[i]     = '0;
        row_two_above[i] = '0;
      end
      col_pos     = 0;
      row_pos     = 0;
      last_height = '0;
      prev_height = '0;
      width_reg   = CFG_WIDTH_RESET;
      height_reg  = CFG_HEIGHT_RESET;
      gain        = 8'(CFG_GAIN_RESET);
      bias        = 8'(CFG_BIAS_RESET);
      mismatches  = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [12:0] val);
      case (idx)
        REG_WIDTH:  width_reg  = val[11:0];
        REG_HEIGHT: height_reg = val;
        REG_GAIN:   gain       = val[7:0];
        REG_BIAS:   bias       = val[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_normals.size();
    endfunction

    // bias plus scaled difference, wrapped to a byte
    function logic [7:0] grad(int unsigned a, int unsigned b);
      logic [31:0] t;
      t = bias + (a - b) * gain;
      return t[7:0];
    endfunction

    function nrm_t make_normal(int unsigned l, int unsigned r, int unsigned u,
                               int unsigned d, int unsigned col, int unsigned row,
                               bit frame_end);
      nrm_t n;
      n.normal_x    = grad(l, r);
      n.normal_y    = grad(u, d);
      n.out_col     = col[OUT_COL_W-1:0];
      n.out_row     = row[OUT_ROW_W-1:0];
      n.last_of_run = 1'b0;
      n.frame_done  = frame_end;
      return n;
    endfunction

    function void absorb_pixel(pix_t p);
      int unsigned w, hh, x, y, hv, c, l, r, u;
      nrm_t        batch[$];
      w  = (width_reg == 0) ? 1 : ((width_reg > MAX_COLS) ? MAX_COLS : width_reg);
      hh = (height_reg == 0) ? 1 : ((height_reg > MAX_ROWS) ? MAX_ROWS : height_reg);

      // a shrunken frame restarts, a shrunken row wraps
      if (row_pos >= hh) begin
        row_pos = 0;
        col_pos = 0;
      end else if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= hh) row_pos = 0;
      end
      x = col_pos;
      y = row_pos;

      hv = (int'(p.pix_red) * 11 + int'(p.pix_green) * 16 + int'(p.pix_blue) * 5) >> 5;

      // pixel one row up is complete now
      if (y > 0) begin
        c = row_above[x];
        l = (x > 0) ? row_two_above[x-1] : c;
        r = (x + 1 < w) ? row_above[x+1] : c;
        u = (y >= 2) ? row_two_above[x] : c;
        batch.push_back(make_normal(l, r, u, hv, x, y - 1, 1'b0));
      end
      // bottom row trails its input by one column, corner closes the frame
      if (y + 1 == hh) begin
        if (x > 0) begin
          c = last_height;
          l = (x >= 2) ? prev_height : c;
          u = (y > 0) ? row_two_above[x-1] : c;
          batch.push_back(make_normal(l, hv, u, c, x - 1, y, 1'b0));
        end
        if (x + 1 == w) begin
          l = (x > 0) ? last_height : hv;
          u = (y > 0) ? row_above[x] : hv;
          batch.push_back(make_normal(l, hv, u, hv, x, y, 1'b1));
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last_of_run = 1'b1;
      foreach (batch[i]) pending_normals.push_back(batch[i]);

      row_two_above[x] = row_above[x];
      row_above[x]     = hv[7:0];
      prev_height      = last_height;
      last_height      = hv[7:0];

      if (x + 1 >= w) begin
        col_pos = 0;
        row_pos = (y + 1 >= hh) ? 0 : y + 1;
      end else begin
        col_pos = x + 1;
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      // keep the log bounded when things go badly wrong
      if (mismatches <= PRINT_CAP) $display("ERROR: %s", msg);
    endtask

    task compare_field(string name, int unsigned got, int unsigned want, nrm_t ref_beat);
      if (got !== want)
        report_mismatch($sformatf("normal beat (col %0d, row %0d): %s got %0d, want %0d",
                                  ref_beat.out_col, ref_beat.out_row, name, got, want));
    endtask

    task check_normal(nrm_t got);
      nrm_t want;
      if (pending_normals.size() == 0) begin
        report_mismatch($sformatf("normal beat (col %0d, row %0d) with nothing pending",
                                  got.out_col, got.out_row));
      end else begin
        want = pending_normals.pop_front();
        compare_field("normal_x", got.normal_x, want.normal_x, want);
        compare_field("normal_y", got.normal_y, want.normal_y, want);
        compare_field("out_col", got.out_col, want.out_col, want);
        compare_field("out_row", got.out_row, want.out_row, want);
        compare_field("last_of_run", got.last_of_run, want.last_of_run, want);
        compare_field("frame_done", got.frame_done, want.frame_done, want);
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n;
  // random idling on both sides is switched per phase
  bit          idle_gaps;
  int unsigned cycles = 0;

  normal_map_checker sb = new();

  hmn_pix_if pix_ch();
  hmn_nrm_if nrm_ch();
  hmn_cfg_if cfg_ch();

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  heightmap_normal_map_unit #(
    .MAX_WIDTH  (MAX_COLS),
    .MAX_HEIGHT (MAX_ROWS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch),
    .out_nrm (nrm_ch),
    .cfg_wr  (cfg_ch)
  );

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // every normal beat is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && nrm_ch.valid && nrm_ch.ready) sb.check_normal(nrm_ch.data);
  end

  // receiver: ready drops in random bursts while idling is on
  initial begin
    nrm_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_gaps && $urandom_range(0, 5) == 0) begin
        nrm_ch.ready = 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        nrm_ch.ready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  function pix_t rgb(int unsigned r, int unsigned g, int unsigned b);
    pix_t p;
    p.pix_red   = r[7:0];
    p.pix_green = g[7:0];
    p.pix_blue  = b[7:0];
    return p;
  endfunction

  function pix_t random_pixel();
    return rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  // one pixel beat; valid stays high into the next call unless a gap is drawn
  task send_pixel(pix_t p);
    int gap;
    gap = (idle_gaps && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      pix_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid = 1'b1;
    pix_ch.data  = p;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    sb.absorb_pixel(p);
  endtask

  // stop sending, wait out every pending normal, then let the pipe empty
  task settle();
    @(negedge clk);
    pix_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register beats only go out while the block is idle
  task write_register(cfg_reg_t idx, int unsigned val);
    @(negedge clk);
    cfg_ch.valid             = 1'b1;
    cfg_ch.data.reg_index    = idx;
    cfg_ch.data.wr_data      = val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_register(idx, val[CFG_DATA_W-1:0]);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // full frame of random pixels, optionally draining once partway
  task run_frame(int w, int h, bit pause);
    int total;
    int pause_at;
    total    = w * h;
    pause_at = pause ? $urandom_range(1, total) : -1;
    for (int i = 0; i < total; i++) begin
      if (i == pause_at) settle();
      send_pixel(random_pixel());
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int fed;
    int w;
    int h;

    pix_ch.valid = 1'b0;
    pix_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    rst_n        = 1'b0;
    idle_gaps    = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // 3x3 frame on the reset gain and bias: silent first row, bottom row
    // two beats per pixel past the first, three on the corner; color extremes
    write_register(REG_WIDTH, 3);
    write_register(REG_HEIGHT, 3);
    send_pixel(rgb(0, 0, 0));
    send_pixel(rgb(255, 255, 255));
    send_pixel(rgb(255, 0, 0));
    send_pixel(rgb(0, 255, 0));
    send_pixel(rgb(0, 0, 255));
    // sender holds off until every normal is back
    settle();
    send_pixel(rgb(255, 255, 255));
    send_pixel(rgb(0, 0, 0));
    send_pixel(rgb(128, 64, 32));
    send_pixel(rgb(255, 255, 255));
    settle();

    // zero sizes act as 1: every pixel is a one-pixel frame
    write_register(REG_WIDTH, 0);
    write_register(REG_HEIGHT, 0);
    write_register(REG_GAIN, 255);
    write_register(REG_BIAS, 0);
    send_pixel(rgb(255, 255, 255));
    send_pixel(rgb(0, 0, 0));
    settle();

    // 4x5 frame, width shrinks mid-row so a new row starts, then height
    // shrinks below the current row so the frame restarts as 2x2
    write_register(REG_WIDTH, 4);
    write_register(REG_HEIGHT, 5);
    write_register(REG_GAIN, 1);
    write_register(REG_BIAS, 255);
    repeat (6) send_pixel(random_pixel());
    settle();
    write_register(REG_WIDTH, 2);
    repeat (2) send_pixel(random_pixel());
    settle();
    write_register(REG_HEIGHT, 2);
    write_register(REG_GAIN, 0);
    repeat (4) send_pixel(random_pixel());
    settle();

    // oversized width clamps to the limit: start of one wide bottom row
    write_register(REG_WIDTH, 4095);
    write_register(REG_HEIGHT, 1);
    write_register(REG_GAIN, $urandom_range(0, 255));
    write_register(REG_BIAS, $urandom_range(0, 255));
    repeat (EDGE_ITEMS) send_pixel(random_pixel());
    settle();

    // oversized height clamps to the limit: one column, rows stream with no
    // idling; the shrunken row wraps and the next size write restarts
    idle_gaps = 1'b0;
    write_register(REG_WIDTH, 1);
    write_register(REG_HEIGHT, 8191);
    write_register(REG_GAIN, $urandom_range(0, 255));
    write_register(REG_BIAS, $urandom_range(0, 255));
    repeat (EDGE_ITEMS) send_pixel(random_pixel());

    // random small frames with random gain and bias, calm at the end
    fed = 0;
    while (fed < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      settle();
      idle_gaps = (fed < CALM_TAIL_AT) && ($urandom_range(0, 3) != 0);
      write_register(REG_WIDTH, w);
      write_register(REG_HEIGHT, h);
      write_register(REG_GAIN, $urandom_range(0, 255));
      write_register(REG_BIAS, $urandom_range(0, 255));
      run_frame(w, h, $urandom_range(0, 3) == 0);
      fed += w * h;
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
